FILE: rtl/wsfd_pkg.sv
`default_nettype none

package wsfd_pkg;

  localparam int unsigned LenW = 64;

  localparam logic [3:0] OpText   = 4'h1;
  localparam logic [3:0] OpBinary = 4'h2;
  localparam logic [3:0] OpClose  = 4'h8;
  localparam logic [3:0] OpMask   = 4'hF;

  localparam logic [6:0] LenMask  = 7'h7F;
  localparam logic [6:0] LenExt16 = 7'd126;
  localparam logic [6:0] LenExt64 = 7'd127;

  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;

  typedef enum logic [1:0] {
    EvByte  = 2'd0,
    EvEmpty = 2'd1,
    EvClose = 2'd2
  } ev_kind_e;

  typedef struct packed {
    logic       valid;
    ev_kind_e   kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/wsfd_rx_if.sv
`default_nettype none

interface wsfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/wsfd_ev_if.sv
`default_nettype none

interface wsfd_ev_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] payload_byte;
  logic [3:0] frame_opcode;
  logic       last_of_frame;

  modport source (output valid, output event_kind, output payload_byte,
                  output frame_opcode, output last_of_frame, input ready);
  modport sink (input valid, input event_kind, input payload_byte,
                input frame_opcode, input last_of_frame, output ready);
endinterface

`default_nettype wire

FILE: rtl/websocket_frame_deframer_unit.sv
`default_nettype none

// Channel  Dir  Fields                                               Handshake
// rx_i     in   rx_byte[7:0]                                         valid/ready
// ev_o     out  event_kind[1:0] payload_byte[7:0] frame_opcode[3:0]  valid/ready
//              last_of_frame
//
// One word is taken per cycle while the event register is not held full. A word
// goes through an input register, the parser state update, and an event register;
// it leaves the input register only when the event register is free or being taken.
// The 64-bit length counter decrement is the widest path.
// Reset clears the parse state and both valid flags. When the event register is
// full and not taken, a word in the input register holds and rx_i.ready drops.

module websocket_frame_deframer_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wsfd_rx_if.sink   rx_i,
  wsfd_ev_if.source ev_o
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q;
  wsfd_pkg::result_t out_q;
  wsfd_pkg::result_t res;
  logic              advance;

  assign advance    = in_valid_q && (!out_valid_q || ev_o.ready);
  assign rx_i.ready = !in_valid_q || advance;

  wsfd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rx_i.ready) begin
        in_valid_q <= rx_i.valid;
      end
      if (advance) begin
        out_valid_q <= res.valid;
      end else if (ev_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
    if (advance && res.valid) begin
      out_q <= res;
    end
  end

  assign ev_o.valid         = out_valid_q;
  assign ev_o.event_kind    = out_q.kind;
  assign ev_o.payload_byte  = out_q.data;
  assign ev_o.frame_opcode  = out_q.opcode;
  assign ev_o.last_of_frame = out_q.last;

endmodule

`default_nettype wire

FILE: rtl/wsfd_parser.sv
`default_nettype none

module wsfd_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [7:0]         byte_i,
  output wsfd_pkg::result_t       res_o
);

  typedef enum logic [2:0] {
    PhHeader = 3'd0,
    PhLength = 3'd1,
    PhExtLen = 3'd2,
    PhData   = 3'd3,
    PhSkip   = 3'd4
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic [3:0]                  opcode_q, opcode_d;
  logic [wsfd_pkg::LenW-1:0]   remain_q, remain_d;
  logic [3:0]                  ext_left_q, ext_left_d;
  logic                        closed_q, closed_d;

  logic [6:0]                  len_code;
  logic [wsfd_pkg::LenW-1:0]   ext_acc;
  logic [3:0]                  ext_left_dec;
  logic                        hdr_done;
  logic [wsfd_pkg::LenW-1:0]   hdr_len;
  logic                        is_data;
  logic [wsfd_pkg::LenW-1:0]   remain_dec;
  logic                        remain_last;

  assign len_code     = byte_i[6:0] & wsfd_pkg::LenMask;
  assign ext_acc      = {remain_q[wsfd_pkg::LenW-9:0], byte_i};
  assign ext_left_dec = (ext_left_q != 4'd0) ? ext_left_q - 4'd1 : 4'd0;
  assign is_data      = (opcode_q == wsfd_pkg::OpText) || (opcode_q == wsfd_pkg::OpBinary);
  assign remain_dec   = remain_q - {{(wsfd_pkg::LenW-1){1'b0}}, 1'b1};
  assign remain_last  = (remain_q == {{(wsfd_pkg::LenW-1){1'b0}}, 1'b1});

  always_comb begin
    phase_d    = phase_q;
    opcode_d   = opcode_q;
    remain_d   = remain_q;
    ext_left_d = ext_left_q;
    closed_d   = closed_q;
    hdr_done   = 1'b0;
    hdr_len    = '0;
    res_o      = '0;

    if (step_i && !closed_q) begin
      case (phase_q)
        PhLength: begin
          remain_d = '0;
          if (len_code == wsfd_pkg::LenExt16) begin
            ext_left_d = wsfd_pkg::ExtBytes16;
            phase_d    = PhExtLen;
          end else if (len_code == wsfd_pkg::LenExt64) begin
            ext_left_d = wsfd_pkg::ExtBytes64;
            phase_d    = PhExtLen;
          end else begin
            ext_left_d = 4'd0;
            remain_d   = {{(wsfd_pkg::LenW-7){1'b0}}, len_code};
            hdr_done   = 1'b1;
            hdr_len    = {{(wsfd_pkg::LenW-7){1'b0}}, len_code};
          end
        end
        PhExtLen: begin
          remain_d   = ext_acc;
          ext_left_d = ext_left_dec;
          if (ext_left_dec == 4'd0) begin
            hdr_done = 1'b1;
            hdr_len  = ext_acc;
          end
        end
        PhData: begin
          remain_d = remain_dec;
          if (remain_last) begin
            phase_d = PhHeader;
          end
          res_o.valid  = 1'b1;
          res_o.kind   = wsfd_pkg::EvByte;
          res_o.data   = byte_i;
          res_o.opcode = opcode_q;
          res_o.last   = remain_last;
        end
        PhSkip: begin
          remain_d = remain_dec;
          if (remain_last) begin
            phase_d = PhHeader;
          end
        end
        default: begin
          opcode_d   = byte_i[3:0] & wsfd_pkg::OpMask;
          remain_d   = '0;
          ext_left_d = 4'd0;
          if ((byte_i[3:0] & wsfd_pkg::OpMask) == wsfd_pkg::OpClose) begin
            closed_d     = 1'b1;
            phase_d      = PhHeader;
            res_o.valid  = 1'b1;
            res_o.kind   = wsfd_pkg::EvClose;
            res_o.opcode = wsfd_pkg::OpClose;
            res_o.last   = 1'b1;
          end else begin
            phase_d = PhLength;
          end
        end
      endcase

      // Once the length is known, pick data, skip, an empty-frame event (data frames), or the next header.
      if (hdr_done) begin
        if (is_data) begin
          if (hdr_len == '0) begin
            phase_d      = PhHeader;
            res_o.valid  = 1'b1;
            res_o.kind   = wsfd_pkg::EvEmpty;
            res_o.opcode = opcode_q;
            res_o.last   = 1'b1;
          end else begin
            phase_d = PhData;
          end
        end else begin
          phase_d = (hdr_len == '0) ? PhHeader : PhSkip;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      opcode_q   <= 4'd0;
      remain_q   <= '0;
      ext_left_q <= 4'd0;
      closed_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      opcode_q   <= opcode_d;
      remain_q   <= remain_d;
      ext_left_q <= ext_left_d;
      closed_q   <= closed_d;
    end
  end

endmodule

`default_nettype wire
